@@ hdl/scpm_pkg.sv @@
package scpm_pkg;

    // Command codes
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_PULSE  = 2'd0;
    localparam t_cmd CMD_ANGLE  = 2'd1;
    localparam t_cmd CMD_LIMITS = 2'd2;

    // Default channel count
    localparam int CHANNELS_DEF = 16;

    // Field widths
    localparam int LIMIT_W = 12;
    localparam int COUNT_W = 13;

    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [COUNT_W-1:0] t_count;

    // Device register map: first channel's on-low byte
    localparam logic [7:0] REG_BASE = 8'd6;

    // Limit values after reset
    localparam t_limit LOWER_RESET = 12'd159;
    localparam t_limit UPPER_RESET = 12'd456;

    // Pulse codes
    localparam t_limit PULSE_MAX = 12'd4095;
    localparam t_count FULL_CODE = 13'd4096;

    // floor(x / 180) = (x * DEG_RECIP) >> DEG_SHIFT, exact for x < 4096
    localparam int           DEG_SHIFT = 20;
    localparam logic [12:0]  DEG_RECIP = 13'd5826;
    localparam int           PROD_W    = 25;

endpackage

@@ hdl/servo_channel_pulse_mapper.sv @@
// Pulse and angle commands: first register write beat 4 cycles after acceptance,
// then four beats, one a cycle without back-pressure: 8 cycles per command.
// set_limits and ignored commands take 1 cycle. The limit RAM read, the degree
// scaling multiplier and the four output beats set these figures.
// Reset (synchronous, active low) marks every channel's limits as unwritten,
// so they read as 159 and 456 until set; no clearing pass is needed.
module servo_channel_pulse_mapper import scpm_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_channel,
    input  logic signed [12:0] i_value,
    input  logic               i_invert,
    input  logic [11:0]        i_limit_low_in,
    input  logic [11:0]        i_limit_high_in,
    // register write channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_reg_addr,
    output logic [7:0]         o_reg_data,
    output logic               o_last
);

    localparam int AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EntryW = 2 * LIMIT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_beat, n_beat;
    logic [CHANNELS-1:0] r_valid;

    logic               w_accept, w_in_range, w_wr, w_rd;
    logic [6:0]         w_ch_ext;
    logic [AddrW-1:0]   w_addr;
    logic [EntryW-1:0]  w_rdata;

    // command registers
    t_cmd               r_cmd;
    logic [3:0]         r_ch;
    logic signed [12:0] r_value;
    logic               r_invert;
    logic               r_rd_valid;

    // datapath registers
    t_limit             r_lo, r_hi, r_mid;
    logic               r_neg;
    logic [PROD_W-1:0]  r_prod;
    logic signed [19:0] r_scaled;
    t_count             r_on, r_off;

    // ---------------- input side ----------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ch_ext   = 7'(i_channel);
    assign w_in_range = w_ch_ext < 7'(CHANNELS);
    assign w_addr     = w_ch_ext[AddrW-1:0];
    assign w_wr       = w_accept && w_in_range && (i_cmd == CMD_LIMITS);
    assign w_rd       = w_accept && w_in_range &&
                        ((i_cmd == CMD_PULSE) || (i_cmd == CMD_ANGLE));

    scpm_ram #(
        .WIDTH (EntryW),
        .DEPTH (CHANNELS)
    ) u_limits (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_re    (w_rd),
        .i_addr  (w_addr),
        .i_wdata ({i_limit_high_in, i_limit_low_in}),
        .o_rdata (w_rdata)
    );

    // ---------------- stage: RAM data back ----------------
    t_limit             w_lo, w_hi, w_mag, w_mid;
    logic [10:0]        w_half;
    logic signed [12:0] w_steps, w_mid_s, w_half_s;

    always_comb begin
        w_lo     = r_rd_valid ? w_rdata[LIMIT_W-1:0]      : LOWER_RESET;
        w_hi     = r_rd_valid ? w_rdata[EntryW-1:LIMIT_W] : UPPER_RESET;
        w_steps  = $signed({1'b0, w_hi}) - $signed({1'b0, w_lo});
        w_mag    = w_steps[12] ? 12'(-w_steps) : w_steps[11:0];
        w_half   = w_mag[11:1];
        w_half_s = $signed({2'b00, w_half});
        // midpoint with half range truncated toward zero
        w_mid_s  = $signed({1'b0, w_lo}) + (w_steps[12] ? -w_half_s : w_half_s);
        w_mid    = w_mid_s[11:0];
    end

    // ---------------- stage: step per degree times angle ----------------
    logic [4:0]         w_pd_mag;
    logic signed [19:0] w_pd, w_neg_val, w_scaled;

    always_comb begin
        w_pd_mag  = r_prod[DEG_SHIFT +: 5];
        w_pd      = r_neg ? -$signed({15'd0, w_pd_mag}) : $signed({15'd0, w_pd_mag});
        w_neg_val = -$signed({{7{r_value[12]}}, r_value});
        w_scaled  = w_neg_val * w_pd;
    end

    // ---------------- stage: clamp and code mapping ----------------
    logic signed [20:0] w_pwm, w_in, w_lo21, w_hi21, w_clamp;
    t_limit             w_v;
    logic               w_inv, w_full_on, w_full_off;
    t_count             w_on, w_off;

    always_comb begin
        w_pwm  = $signed({9'd0, r_mid}) + $signed({r_scaled[19], r_scaled});
        w_in   = (r_cmd == CMD_PULSE) ? $signed({{8{r_value[12]}}, r_value}) : w_pwm;
        w_lo21 = $signed({9'd0, r_lo});
        w_hi21 = $signed({9'd0, r_hi});
        // lower limit first, then upper, so reversed limits leave the upper one
        w_clamp = (w_in < w_lo21) ? w_lo21 : w_in;
        if (w_clamp > w_hi21) begin
            w_clamp = w_hi21;
        end
        w_v = w_clamp[11:0];

        w_inv      = (r_cmd == CMD_PULSE) && r_invert;
        w_full_on  = w_inv ? (w_v == '0) : (w_v == PULSE_MAX);
        w_full_off = w_inv ? (w_v == PULSE_MAX) : (w_v == '0);
        priority if (w_full_on) begin
            w_on  = FULL_CODE;
            w_off = '0;
        end else if (w_full_off) begin
            w_on  = '0;
            w_off = FULL_CODE;
        end else begin
            w_on  = '0;
            w_off = {1'b0, (w_inv ? (PULSE_MAX - w_v) : w_v)};
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_beat  = r_beat;
        unique case (r_state)
            S_IDLE: begin
                if (w_rd) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM: begin
                n_state = S_EMIT;
                n_beat  = '0;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_beat = r_beat + 2'd1;
                    if (r_beat == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_beat  <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_beat  <= n_beat;
            if (w_wr) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_cmd;
            r_ch       <= i_channel;
            r_value    <= i_value;
            r_invert   <= i_invert;
            r_rd_valid <= r_valid[w_addr];
        end
        if (r_state == S_READ) begin
            r_lo   <= w_lo;
            r_hi   <= w_hi;
            r_mid  <= w_mid;
            r_neg  <= w_steps[12];
            r_prod <= PROD_W'(w_mag) * PROD_W'(DEG_RECIP);
        end
        if (r_state == S_MUL) begin
            r_scaled <= w_scaled;
        end
        if (r_state == S_SUM) begin
            r_on  <= w_on;
            r_off <= w_off;
        end
    end

    // ---------------- output beats ----------------
    assign o_out_valid = (r_state == S_EMIT);
    assign o_reg_addr  = REG_BASE + {2'b00, r_ch, 2'b00} + {6'd0, r_beat};
    assign o_last      = o_out_valid && (r_beat == 2'd3);

    always_comb begin
        unique case (r_beat)
            2'd0: o_reg_data = r_on[7:0];
            2'd1: o_reg_data = {3'd0, r_on[12:8]};
            2'd2: o_reg_data = r_off[7:0];
            2'd3: o_reg_data = {3'd0, r_off[12:8]};
            default: o_reg_data = '0;
        endcase
    end

    // ---------------- assertions ----------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("command taken while register beats pending");

    a_first_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd) |-> ##4 (o_out_valid && (r_beat == 2'd0)))
        else $error("pulse command did not reach first beat on time");

    a_beat_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last)
            |=> (o_out_valid && (o_reg_addr == $past(o_reg_addr) + 8'd1)))
        else $error("register beats out of order");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("not idle after last beat");

endmodule

@@ hdl/scpm_ram.sv @@
module scpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
